// ===== rtl/fyshuf_pkg.sv =====
package fyshuf_pkg;

    // Storage geometry.
    localparam int DEPTH  = 1024;
    localparam int ELEM_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Draw value and range stay below 2 * DEPTH.
    localparam int DW     = IDX_W + 1;

    // Port field widths.
    localparam int ACT_W    = 2;
    localparam int DATA_W   = 32;
    localparam int WORD_W   = 64;
    localparam int RIDX_W   = 10;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 11;
    localparam int LEFT_W   = $clog2(WORD_W + 1);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_PUSH    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WORD    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ    = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd3;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_WAIT   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_SWAP_RD,
        ST_SWAP_WI,
        ST_SWAP_WJ,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear_all;
        logic load_word;
        logic start;
        logic step;
    } draw_ctrl_t;

    typedef struct packed {
        logic             have_bits;
        logic             hit;
        logic [IDX_W-1:0] pick;
    } draw_stat_t;

endpackage

// ===== rtl/fyshuf_in_if.sv =====
interface fyshuf_in_if
    import fyshuf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [DATA_W-1:0] element_value;
    logic [WORD_W-1:0] random_word;
    logic [RIDX_W-1:0] read_index;

    modport source (
        output valid, action, element_value, random_word, read_index,
        input  ready
    );

    modport sink (
        input  valid, action, element_value, random_word, read_index,
        output ready
    );
endinterface

// ===== rtl/fyshuf_out_if.sv =====
interface fyshuf_out_if
    import fyshuf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]  placed_count;
    logic              all_done;

    modport source (
        output valid, status, read_value, placed_count, all_done,
        input  ready
    );

    modport sink (
        input  valid, status, read_value, placed_count, all_done,
        output ready
    );
endinterface

// ===== rtl/fyshuf_store.sv =====
module fyshuf_store
    import fyshuf_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [ELEM_W-1:0] wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [ELEM_W-1:0] rdata
);

    logic [ELEM_W-1:0] store_reg [DEPTH];
    logic [ELEM_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fyshuf_draw.sv =====
module fyshuf_draw
    import fyshuf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  draw_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] word,
    input  logic [DW-1:0]     n,
    output draw_stat_t        stat
);

    logic [WORD_W-1:0] buf_reg, buf_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [DW-1:0]     d_reg, d_next;
    logic [DW-1:0]     v_reg, v_next;

    logic [DW-1:0] d2;
    logic [DW-1:0] v2;
    logic          range_ok;
    logic          value_ok;

    // One doubling step; the value always stays below the range, and the
    // range no greater than n, so the top bit can be dropped before the shift.
    assign d2       = {d_reg[IDX_W-1:0], buf_reg[0]};
    assign v2       = {v_reg[IDX_W-1:0], 1'b0};
    assign range_ok = (v2 >= n);
    assign value_ok = (d2 < n);

    assign stat.have_bits = (left_reg != '0);
    assign stat.hit       = range_ok && value_ok;
    assign stat.pick      = d2[IDX_W-1:0];

    always_comb
    begin
        buf_next  = buf_reg;
        left_next = left_reg;
        d_next    = d_reg;
        v_next    = v_reg;
        if (ctrl.clear_all)
        begin
            buf_next  = '0;
            left_next = '0;
            d_next    = '0;
            v_next    = DW'(1);
        end
        else if (ctrl.load_word)
        begin
            buf_next  = word;
            left_next = LEFT_W'(WORD_W);
        end
        else if (ctrl.start)
        begin
            d_next = '0;
            v_next = DW'(1);
        end
        else if (ctrl.step)
        begin
            buf_next  = buf_reg >> 1;
            left_next = left_reg - LEFT_W'(1);
            if (range_ok && value_ok)
            begin
                d_next = '0;
                v_next = DW'(1);
            end
            else if (range_ok)
            begin
                d_next = d2 - n;
                v_next = v2 - n;
            end
            else
            begin
                d_next = d2;
                v_next = v2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg  <= '0;
            left_reg <= '0;
            d_reg    <= '0;
            v_reg    <= DW'(1);
        end
        else
        begin
            buf_reg  <= buf_next;
            left_reg <= left_next;
            d_reg    <= d_next;
            v_reg    <= v_next;
        end
    end

endmodule

// ===== rtl/bit_efficient_fisher_yates_shuffle.sv =====
// A push or a random word is accepted in idle and runs the pending draw, consuming random bits;
// a landed draw then passes through the swap read, write-i and write-j states. A read passes
// through the read state, a restart or a rejected item goes straight to done, and each result
// loads once the output register is free. One item is in work at a time; the next is taken in idle.
// Pushes are paced by the bit-serial draw unit.
// Reset clears the sequencer, the draw and the bit buffer and sets the length to 1024; the
// element store is not cleared and holds undefined data until each entry is pushed.
module bit_efficient_fisher_yates_shuffle
    import fyshuf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_wdata,
    fyshuf_in_if.sink        req,
    fyshuf_out_if.source     rsp
);

    // Sequencer state and per-item working registers.
    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  len_reg;
    logic [ELEM_W-1:0] push_val_reg, push_val_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] rval_reg, rval_next;

    // Output register, which lets the next item be taken while a result waits.
    logic              out_valid_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [DATA_W-1:0] out_rval_reg;
    logic [LEN_W-1:0]  out_placed_reg;
    logic              out_done_reg;
    logic              result_load;

    // Store port and draw unit connections.
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [ELEM_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    logic [ELEM_W-1:0] mem_rdata;
    draw_ctrl_t        dctrl;
    draw_stat_t        dstat;
    logic [DW-1:0]     draw_n;

    logic [CNT_W-1:0]  eff_len;
    logic [IDX_W-1:0]  fill_idx;
    logic              full;
    logic              rd_bad;
    logic              accept;

    // The effective length is the configured length capped at the store depth.
    assign eff_len  = (32'(len_reg) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(len_reg);
    assign full     = (fill_reg >= eff_len);
    assign fill_idx = fill_reg[IDX_W-1:0];
    assign draw_n   = DW'(fill_reg) + DW'(1);
    assign rd_bad   = (32'(req.read_index) >= 32'(DEPTH));

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    fyshuf_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fyshuf_draw u_draw (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dctrl),
        .word  (req.random_word),
        .n     (draw_n),
        .stat  (dstat)
    );

    // The sequencer. A push writes its element at the fill position at once, so
    // that a read during a waiting draw sees it, and keeps a copy for the swap.
    // The draw then runs one bit per cycle while random bits remain; when it lands on j,
    // the swap reads element j, writes it to the fill position and writes the pushed copy to j.
    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        pend_next     = pend_reg;
        push_val_next = push_val_reg;
        j_next        = j_reg;
        status_next   = status_reg;
        rval_next     = rval_reg;
        mem_we        = 1'b0;
        mem_waddr     = fill_idx;
        mem_wdata     = mem_rdata;
        mem_raddr     = j_reg;
        dctrl         = '0;
        result_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    status_next = STAT_OK;
                    rval_next   = '0;
                    case (req.action)
                        ACT_PUSH:
                        begin
                            if (pend_reg || full)
                            begin
                                status_next = STAT_REJECT;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                mem_we        = 1'b1;
                                mem_wdata     = ELEM_W'(req.element_value);
                                push_val_next = ELEM_W'(req.element_value);
                                pend_next     = 1'b1;
                                dctrl.start   = 1'b1;
                                state_next    = ST_DRAW;
                            end
                        end
                        ACT_WORD:
                        begin
                            dctrl.load_word = 1'b1;
                            state_next      = ST_DRAW;
                        end
                        ACT_READ:
                        begin
                            if (rd_bad)
                            begin
                                status_next = STAT_REJECT;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                mem_raddr  = IDX_W'(req.read_index);
                                state_next = ST_READ;
                            end
                        end
                        ACT_RESTART:
                        begin
                            fill_next       = '0;
                            pend_next       = 1'b0;
                            dctrl.clear_all = 1'b1;
                            state_next      = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DRAW:
            begin
                if (pend_reg && dstat.have_bits)
                begin
                    dctrl.step = 1'b1;
                    if (dstat.hit)
                    begin
                        j_next     = dstat.pick;
                        state_next = ST_SWAP_RD;
                    end
                end
                else
                begin
                    status_next = pend_reg ? STAT_WAIT : STAT_OK;
                    state_next  = ST_DONE;
                end
            end
            ST_SWAP_RD:
            begin
                mem_raddr  = j_reg;
                state_next = ST_SWAP_WI;
            end
            ST_SWAP_WI:
            begin
                mem_we     = 1'b1;
                mem_waddr  = fill_idx;
                mem_wdata  = mem_rdata;
                state_next = ST_SWAP_WJ;
            end
            ST_SWAP_WJ:
            begin
                mem_we      = 1'b1;
                mem_waddr   = j_reg;
                mem_wdata   = push_val_reg;
                fill_next   = fill_reg + CNT_W'(1);
                pend_next   = 1'b0;
                status_next = STAT_OK;
                state_next  = ST_DONE;
            end
            ST_READ:
            begin
                rval_next  = DATA_W'(mem_rdata);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            len_reg       <= LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
            if (cfg_we)
            begin
                len_reg <= cfg_wdata;
            end
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        push_val_reg <= push_val_next;
        j_reg        <= j_next;
        status_reg   <= status_next;
        rval_reg     <= rval_next;
        if (result_load)
        begin
            out_status_reg <= status_reg;
            out_rval_reg   <= rval_reg;
            out_placed_reg <= LEN_W'(fill_reg);
            out_done_reg   <= (fill_reg == eff_len);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.read_value   = out_rval_reg;
    assign rsp.placed_count = out_placed_reg;
    assign rsp.all_done     = out_done_reg;

    // A draw is only ever pending for a position inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (fill_reg < CNT_W'(DEPTH)))
        else $error("draw pending beyond the store depth");

    // A landed draw always goes straight on to the swap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAW && dctrl.step && dstat.hit) |=> (state_reg == ST_SWAP_RD))
        else $error("landed draw did not start the swap");

    // Completing a swap places exactly one more element.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWAP_WJ) |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("swap did not advance the fill position");

    // A restart leaves an empty array with no draw pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ACT_RESTART) |=> (fill_reg == '0 && !pend_reg))
        else $error("restart did not empty the array");

endmodule
